// ----- rtl/bbc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the bracket balance checker: sizes, kind and status codes, result type.
package bbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int KIND_W      = 2;
	localparam int DEPTH_W     = 7;

	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_UNCLOSED = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

	typedef struct packed {
		logic               is_final;
		logic [1:0]         status;
		logic [DEPTH_W-1:0] nesting_depth;
	} result_t;

endpackage

// ----- rtl/bracket_balance_checker_unit.sv -----
`timescale 1ns / 1ps
// Top level of the bracket balance checker: stack control, kind RAM and result buffer.
//
//  Channel  Signals                              Direction  Beat
//  input    in_valid, in_stall, text_byte,       in         one character of the text
//           end_of_text
//  output   out_valid, out_stall, is_final,      out        status and depth after it
//           status, nesting_depth
//
// One character is taken per cycle while in_stall is low; its result is
// registered into the skid buffer and offered from its result register.
// The top of the stack lives in a register; the RAM holds the entries below
// it and is read each cycle at the slot under the top, so a pop finds its new
// top without waiting. A push writes the old top to the very slot being read,
// and that value is forwarded for one cycle.
// Reset clears the stack pointer, the error latch and the valid flags; the
// RAM needs no clearing, since only slots below the pointer are ever used.
// in_stall rises only when both the result register and the skid slot are
// full, so a held result does not stop the next character from entering.
module bracket_balance_checker_unit
	import bbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         text_byte,
	input  logic               end_of_text,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_final,
	output logic [1:0]         status,
	output logic [DEPTH_W-1:0] nesting_depth
);

	logic [SP_W-1:0]   sp_q;
	logic [1:0]        err_q;
	logic [KIND_W-1:0] top_q;
	logic              fwd_q;
	logic [KIND_W-1:0] fwd_val_q;

	logic [KIND_W-1:0] rd_data;
	logic [KIND_W-1:0] under;
	logic [KIND_W-1:0] kind;
	logic              is_open;
	logic              is_close;
	logic              accept;

	logic [SP_W-1:0]   sp_new;
	logic [1:0]        err_new;
	logic [KIND_W-1:0] top_new;
	logic              wr_en;
	logic [SP_W-1:0]   sp_next;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	result_t res;
	logic    res_stall;

	assign accept   = in_valid && !res_stall;
	assign in_stall = res_stall;

	// Character decode.
	always_comb begin
		kind     = KIND_NONE;
		is_open  = 1'b0;
		is_close = 1'b0;
		case (text_byte)
			CH_OPEN_ROUND:   begin kind = KIND_ROUND;  is_open  = 1'b1; end
			CH_OPEN_SQUARE:  begin kind = KIND_SQUARE; is_open  = 1'b1; end
			CH_OPEN_CURLY:   begin kind = KIND_CURLY;  is_open  = 1'b1; end
			CH_CLOSE_ROUND:  begin kind = KIND_ROUND;  is_close = 1'b1; end
			CH_CLOSE_SQUARE: begin kind = KIND_SQUARE; is_close = 1'b1; end
			CH_CLOSE_CURLY:  begin kind = KIND_CURLY;  is_close = 1'b1; end
			default:         begin kind = KIND_NONE; end
		endcase
	end

	// The slot under the top comes from the RAM, or from the forwarding
	// register right after a push wrote that slot.
	assign under = fwd_q ? fwd_val_q : rd_data;

	// Push, pop or error for this character; bytes after an error are ignored.
	always_comb begin
		sp_new  = sp_q;
		err_new = err_q;
		top_new = top_q;
		wr_en   = 1'b0;
		if (err_q == ST_OK) begin
			if (is_open) begin
				if (sp_q == SP_W'(STACK_DEPTH)) begin
					err_new = ST_OVERFLOW;
				end else begin
					wr_en   = (sp_q != '0);
					top_new = kind;
					sp_new  = sp_q + SP_W'(1);
				end
			end else if (is_close) begin
				if (sp_q == '0 || top_q != kind) begin
					err_new = ST_MISMATCH;
				end else begin
					top_new = under;
					sp_new  = sp_q - SP_W'(1);
				end
			end
		end
	end

	assign wr_addr = ADDR_W'(sp_q - SP_W'(1));

	always_comb begin
		res.is_final      = end_of_text;
		res.nesting_depth = DEPTH_W'(sp_new);
		if (err_new != ST_OK) begin
			res.status = err_new;
		end else if (end_of_text && sp_new != '0) begin
			res.status = ST_UNCLOSED;
		end else begin
			res.status = ST_OK;
		end
	end

	// Read address follows the pointer as it will be after this edge.
	assign sp_next = !accept ? sp_q : (end_of_text ? '0 : sp_new);
	assign rd_addr = ADDR_W'(sp_next - SP_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			err_q <= ST_OK;
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= accept && wr_en && !end_of_text;
			if (accept) begin
				sp_q  <= end_of_text ? '0 : sp_new;
				err_q <= end_of_text ? ST_OK : err_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_val_q <= top_q;
		if (accept) begin
			top_q <= top_new;
		end
	end

	bbc_ram #(
		.WIDTH(KIND_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (accept && wr_en),
		.wr_addr(wr_addr),
		.wr_data(top_q),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	result_t out_res;

	bbc_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (res_stall),
		.in_data  (res),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_res)
	);

	assign is_final      = out_res.is_final;
	assign status        = out_res.status;
	assign nesting_depth = out_res.nesting_depth;

	// The stack pointer never passes the stack's capacity.
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer above capacity");

	// The error latch never holds the unclosed code: only OK, mismatch or overflow.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != ST_UNCLOSED)
		else $error("error latch holds the unclosed code");

	// A final character leaves an empty stack and a clear latch.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_text |=> sp_q == '0 && err_q == ST_OK)
		else $error("state not cleared after end of text");

	// Forwarding is armed only by a push onto a non-empty stack.
	a_fwd_push: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> $past(accept && is_open && sp_q != '0))
		else $error("forwarding without a push");

endmodule

// ----- rtl/bbc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
	output logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/bbc_skid.sv -----
`timescale 1ns / 1ps
// Output register with a skid stage between the checker logic and the result channel.
module bbc_skid
	import bbc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    take;
	logic    main_free;

	assign in_stall  = skid_valid_q;
	assign take      = in_valid && !skid_valid_q;
	assign main_free = !main_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (take) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule
